### design/area_average_image_scaler_top_defines.svh
// assertion macros for the area-average image scaler
`ifndef AREA_AVERAGE_IMAGE_SCALER_TOP_DEFINES_SVH
`define AREA_AVERAGE_IMAGE_SCALER_TOP_DEFINES_SVH

// same-cycle implication, checked at every rising edge outside reset
`define AAIS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AAIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/aais_pkg.sv
// shared types and constants of the area-average image scaler
`default_nettype none

package aais_pkg;

  localparam int MAX_WIDTH    = 256;
  localparam int MAX_HEIGHT   = 256;
  localparam int MAX_CHANNELS = 4;

  localparam int COORD_W = 8;
  localparam int VAL_W   = 8;
  localparam int PLANES  = 5;
  localparam int PIX_W   = PLANES * VAL_W;
  localparam int ADDR_W  = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int COL_W   = $clog2(MAX_WIDTH);

  // shared divider sizes
  localparam int DIV_W  = 64;
  localparam int DEN_W  = 17;
  localparam int STEP_W = 7;

  localparam logic [STEP_W-1:0] STEPS_COORD  = 7'd17;
  localparam logic [STEP_W-1:0] STEPS_WEIGHT = 7'd25;
  localparam logic [STEP_W-1:0] STEPS_FINAL  = 7'd64;

  // item kinds
  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  // register indexes
  localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [2:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [2:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [2:0] REG_CHAN_COUNT = 3'd4;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [DIV_W-1:0]  num;
    logic [DEN_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

### design/aais_in_if.sv
// input channel: load and request items
`default_nettype none

interface aais_in_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [aais_pkg::COORD_W-1:0] pix_col;
  logic [aais_pkg::COORD_W-1:0] pix_row;
  logic [aais_pkg::VAL_W-1:0]   chan_a;
  logic [aais_pkg::VAL_W-1:0]   chan_b;
  logic [aais_pkg::VAL_W-1:0]   chan_c;
  logic [aais_pkg::VAL_W-1:0]   chan_d;
  logic [aais_pkg::VAL_W-1:0]   alpha_in;

  modport source (output valid, kind, pix_col, pix_row, chan_a, chan_b, chan_c, chan_d,
                  alpha_in, input ready);
  modport sink (input valid, kind, pix_col, pix_row, chan_a, chan_b, chan_c, chan_d,
                alpha_in, output ready);
endinterface

`default_nettype wire

### design/aais_out_if.sv
// output channel: averaged pixel items
`default_nettype none

interface aais_out_if;
  logic                       valid;
  logic                       ready;
  logic [aais_pkg::VAL_W-1:0] out_a;
  logic [aais_pkg::VAL_W-1:0] out_b;
  logic [aais_pkg::VAL_W-1:0] out_c;
  logic [aais_pkg::VAL_W-1:0] out_d;
  logic [aais_pkg::VAL_W-1:0] out_alpha;

  modport source (output valid, out_a, out_b, out_c, out_d, out_alpha, input ready);
  modport sink (input valid, out_a, out_b, out_c, out_d, out_alpha, output ready);
endinterface

`default_nettype wire

### design/aais_div.sv
// shared restoring divider, one quotient bit per cycle
`default_nettype none

module aais_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire aais_pkg::div_req_t req,
  output aais_pkg::div_rsp_t      rsp
);

  logic [aais_pkg::DIV_W-1:0]  work;
  logic [aais_pkg::DEN_W-1:0]  rem;
  logic [aais_pkg::STEP_W-1:0] cnt;
  logic                        busy;
  logic                        done;
  logic [aais_pkg::DEN_W:0]    trial;
  logic                        ge;

  // numerator arrives left-aligned, quotient shifts in from the right
  assign trial = {rem, work[aais_pkg::DIV_W-1]};
  assign ge    = trial >= {1'b0, req.den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      work <= req.num;
      rem  <= '0;
    end else if (busy) begin
      work <= {work[aais_pkg::DIV_W-2:0], ge};
      if (ge) begin
        rem <= aais_pkg::DEN_W'(trial - {1'b0, req.den});
      end else begin
        rem <= trial[aais_pkg::DEN_W-1:0];
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = work;

endmodule

`default_nettype wire

### design/aais_store.sv
// source frame store, one write and one registered read port
`default_nettype none

module aais_store (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [aais_pkg::ADDR_W-1:0] waddr,
  input  wire logic [aais_pkg::PIX_W-1:0]  wdata,
  input  wire logic [aais_pkg::ADDR_W-1:0] raddr,
  output logic      [aais_pkg::PIX_W-1:0]  rdata
);

  logic [aais_pkg::PIX_W-1:0] mem [aais_pkg::MAX_WIDTH * aais_pkg::MAX_HEIGHT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/area_average_image_scaler_top.sv
// top level of the area-average image scaler
`default_nettype none

// Area-averaging (box filter) image scaler. A load item (kind 0) writes one
// source pixel, four channels plus alpha, into a 256x256 frame store. A
// request item (kind 1) names a destination pixel; the block walks every
// source pixel under that pixel's footprint, weights each by its x and y
// overlap fractions (unsigned Q1.16, rounded to nearest), accumulates the
// weighted planes, scales by dst_area/src_area, truncates and clamps to 255.
// Requests outside the destination size give no item. Channels at or above
// channel_count read as zero; alpha is always computed. A request reads only
// store entries that were loaded before it. All multiplication and division
// runs through one shared restoring divider (one quotient bit per cycle) and
// one registered 34x17 multiplier under a small sequencer, so the block takes
// one item at a time and drops ready while a request is in work. A finished
// request waits while the output register stays full. The finished item sits
// in an output register, so the next item is accepted while it waits.
// Configuration must be written only while the block is idle; the block
// itself does not enforce it.

`include "area_average_image_scaler_top_defines.svh"

module area_average_image_scaler_top (
  input  wire logic       clk,
  input  wire logic       rst,
  aais_in_if.sink         in_ch,
  aais_out_if.source      out_ch,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [8:0] cfg_data
);

  // sequencer states
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_MX   = 5'd1;   // col * src_width
  localparam logic [4:0] S_MY   = 5'd2;   // row * src_height
  localparam logic [4:0] S_MA   = 5'd3;   // source area
  localparam logic [4:0] S_MD   = 5'd4;   // destination area
  localparam logic [4:0] S_D0   = 5'd5;   // start first column division
  localparam logic [4:0] S_D0W  = 5'd6;
  localparam logic [4:0] S_D1W  = 5'd7;
  localparam logic [4:0] S_D2W  = 5'd8;
  localparam logic [4:0] S_D3W  = 5'd9;
  localparam logic [4:0] S_RY   = 5'd10;  // row cell start
  localparam logic [4:0] S_RYL  = 5'd11;  // row overlap, start weight divide
  localparam logic [4:0] S_RYW  = 5'd12;
  localparam logic [4:0] S_CX   = 5'd13;  // column cell start
  localparam logic [4:0] S_CXL  = 5'd14;
  localparam logic [4:0] S_CXW  = 5'd15;
  localparam logic [4:0] S_W    = 5'd16;  // wx * wy, store read
  localparam logic [4:0] S_WP   = 5'd17;
  localparam logic [4:0] S_PM   = 5'd18;  // plane * weight
  localparam logic [4:0] S_PA   = 5'd19;  // accumulate
  localparam logic [4:0] S_FM   = 5'd20;  // scale low half
  localparam logic [4:0] S_FH   = 5'd21;  // scale high half
  localparam logic [4:0] S_FS   = 5'd22;  // start final divide
  localparam logic [4:0] S_FW   = 5'd23;
  localparam logic [4:0] S_OUT  = 5'd24;

  localparam logic [2:0] LAST_PLANE = 3'(aais_pkg::PLANES - 1);

  logic [4:0] state;

  // configuration
  logic [8:0] sw, sh, dw, dh;
  logic [2:0] cc;

  // request context
  logic [7:0]  col, row;
  logic [16:0] xlo, ylo, area, dd;
  logic [16:0] xhi, yhi;
  logic [7:0]  sx0, sx1, sy1, sx, sy;
  logic [16:0] wx, wy;
  logic [32:0] w;
  logic [39:0] pix;
  logic [57:0] acc [aais_pkg::PLANES];
  logic [45:0] lo_prod;
  logic [2:0]  p;
  logic [7:0]  res [aais_pkg::PLANES];

  // shared multiplier
  logic [33:0] mul_a;
  logic [16:0] mul_b;
  logic [50:0] mul_p;

  // overlap length for the current cell
  logic [16:0] ov_lo, ov_hi, ov_cs, ov_ce, ov_a, ov_b, ov_len;
  logic [8:0]  ov_d;
  logic [24:0] wnum;

  logic [7:0]  plane;
  logic        plane_used;
  logic [63:0] scaled;

  // output register
  logic       out_valid;
  logic       out_load;
  logic [7:0] o_a, o_b, o_c, o_d, o_alpha;

  aais_pkg::div_req_t div_req;
  aais_pkg::div_rsp_t div_rsp;

  logic                       in_acc;
  logic                       req_go;
  logic                       div_waiting;
  logic                       st_we;
  logic [aais_pkg::PIX_W-1:0] st_rdata;

  function automatic logic [8:0] sat_dim(input logic [8:0] v, input logic [8:0] hi);
    logic [8:0] r;
    r = v;
    if (v == 9'd0) r = 9'd1;
    else if (v > hi) r = hi;
    return r;
  endfunction

  function automatic logic [7:0] clamp_last(input logic [16:0] q, input logic [8:0] n);
    logic [8:0] r;
    r = (q >= {8'd0, n}) ? (n - 9'd1) : q[8:0];
    return r[7:0];
  endfunction

  assign in_ch.ready = (state == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign st_we       = in_acc && (in_ch.kind == aais_pkg::KIND_LOAD);

  // accepted request inside the destination
  assign req_go = in_acc && in_ch.kind == aais_pkg::KIND_REQUEST &&
                  {1'b0, in_ch.pix_col} < dw && {1'b0, in_ch.pix_row} < dh;

  // states that wait on the divider
  assign div_waiting = state == S_D0W || state == S_D1W || state == S_D2W ||
                       state == S_D3W || state == S_RYW || state == S_CXW ||
                       state == S_FW;

  assign out_load = (state == S_OUT) && (!out_valid || out_ch.ready);

  assign xhi = xlo + {8'd0, sw};
  assign yhi = ylo + {8'd0, sh};

  // store entries packed channel 0 in the low byte, alpha on top
  aais_store u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr ({in_ch.pix_row, in_ch.pix_col}),
    .wdata ({in_ch.alpha_in, in_ch.chan_d, in_ch.chan_c, in_ch.chan_b, in_ch.chan_a}),
    .raddr ({sy, sx}),
    .rdata (st_rdata)
  );

  aais_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign plane      = pix[{p, 3'b000} +: 8];
  assign plane_used = (p == LAST_PLANE) || (p < cc);
  assign scaled     = {mul_p[34:0], 29'd0} + {18'd0, lo_prod};

  // overlap of footprint [lo, hi) with cell [cs, cs + d)
  always_comb begin
    if (state == S_RYL) begin
      ov_lo = ylo;
      ov_hi = yhi;
      ov_d  = dh;
    end else begin
      ov_lo = xlo;
      ov_hi = xhi;
      ov_d  = dw;
    end
    ov_cs  = mul_p[16:0];
    ov_ce  = ov_cs + {8'd0, ov_d};
    ov_a   = (ov_lo > ov_cs) ? ov_lo : ov_cs;
    ov_b   = (ov_hi < ov_ce) ? ov_hi : ov_ce;
    ov_len = (ov_b > ov_a) ? (ov_b - ov_a) : 17'd0;
    // weight numerator: len in Q16 plus half a cell for rounding
    wnum   = {ov_len[8:0], 16'd0} + {17'd0, ov_d[8:1]};
  end

  // multiplier operand select
  always_comb begin
    unique case (state)
      S_MX: begin
        mul_a = {26'd0, col};
        mul_b = {8'd0, sw};
      end
      S_MY: begin
        mul_a = {26'd0, row};
        mul_b = {8'd0, sh};
      end
      S_MA: begin
        mul_a = {25'd0, sw};
        mul_b = {8'd0, sh};
      end
      S_MD: begin
        mul_a = {25'd0, dw};
        mul_b = {8'd0, dh};
      end
      S_RY: begin
        mul_a = {26'd0, sy};
        mul_b = {8'd0, dh};
      end
      S_CX: begin
        mul_a = {26'd0, sx};
        mul_b = {8'd0, dw};
      end
      S_W: begin
        mul_a = {17'd0, wx};
        mul_b = wy;
      end
      S_PM: begin
        mul_a = {1'b0, w};
        mul_b = {9'd0, plane};
      end
      S_FM: begin
        mul_a = {5'd0, acc[p][28:0]};
        mul_b = dd;
      end
      S_FH: begin
        mul_a = {5'd0, acc[p][57:29]};
        mul_b = dd;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= 51'(mul_a * mul_b);
  end

  // divider requests; the divisor must hold while a division runs
  always_comb begin
    div_req.start = 1'b0;
    div_req.steps = aais_pkg::STEPS_COORD;
    div_req.num   = '0;
    div_req.den   = {8'd0, dw};
    unique case (state)
      S_D0: begin
        div_req.start = 1'b1;
        div_req.num   = {xlo, 47'd0};
      end
      S_D0W: begin
        div_req.start = div_rsp.done;
        div_req.num   = {xhi - 17'd1, 47'd0};
      end
      S_D1W: begin
        // last column division still runs on dw until it is done
        div_req.start = div_rsp.done;
        div_req.num   = {ylo, 47'd0};
        div_req.den   = div_rsp.done ? {8'd0, dh} : {8'd0, dw};
      end
      S_D2W: begin
        div_req.start = div_rsp.done;
        div_req.num   = {yhi - 17'd1, 47'd0};
        div_req.den   = {8'd0, dh};
      end
      S_D3W: begin
        div_req.den = {8'd0, dh};
      end
      S_RYL: begin
        div_req.start = 1'b1;
        div_req.steps = aais_pkg::STEPS_WEIGHT;
        div_req.num   = {wnum, 39'd0};
        div_req.den   = {8'd0, dh};
      end
      S_RYW: begin
        div_req.steps = aais_pkg::STEPS_WEIGHT;
        div_req.den   = {8'd0, dh};
      end
      S_CXL: begin
        div_req.start = 1'b1;
        div_req.steps = aais_pkg::STEPS_WEIGHT;
        div_req.num   = {wnum, 39'd0};
      end
      S_CXW: begin
        div_req.steps = aais_pkg::STEPS_WEIGHT;
      end
      S_FS: begin
        div_req.start = 1'b1;
        div_req.steps = aais_pkg::STEPS_FINAL;
        div_req.num   = scaled;
        div_req.den   = area;
      end
      S_FW: begin
        div_req.steps = aais_pkg::STEPS_FINAL;
        div_req.den   = area;
      end
      default: begin
      end
    endcase
  end

  // configuration registers, saturated on write
  always_ff @(posedge clk) begin
    if (rst) begin
      sw <= 9'(aais_pkg::MAX_WIDTH);
      sh <= 9'(aais_pkg::MAX_HEIGHT);
      dw <= 9'(aais_pkg::MAX_WIDTH);
      dh <= 9'(aais_pkg::MAX_HEIGHT);
      cc <= 3'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        aais_pkg::REG_SRC_WIDTH:  sw <= sat_dim(cfg_data, 9'(aais_pkg::MAX_WIDTH));
        aais_pkg::REG_SRC_HEIGHT: sh <= sat_dim(cfg_data, 9'(aais_pkg::MAX_HEIGHT));
        aais_pkg::REG_DST_WIDTH:  dw <= sat_dim(cfg_data, 9'(aais_pkg::MAX_WIDTH));
        aais_pkg::REG_DST_HEIGHT: dh <= sat_dim(cfg_data, 9'(aais_pkg::MAX_HEIGHT));
        aais_pkg::REG_CHAN_COUNT: begin
          if (cfg_data[2:0] == 3'd0) cc <= 3'd1;
          else if (cfg_data[2:0] > 3'(aais_pkg::MAX_CHANNELS)) cc <= 3'(aais_pkg::MAX_CHANNELS);
          else cc <= cfg_data[2:0];
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_go) begin
            state <= S_MX;
          end
        end
        S_MX:  state <= S_MY;
        S_MY:  state <= S_MA;
        S_MA:  state <= S_MD;
        S_MD:  state <= S_D0;
        S_D0:  state <= S_D0W;
        S_D0W: if (div_rsp.done) state <= S_D1W;
        S_D1W: if (div_rsp.done) state <= S_D2W;
        S_D2W: if (div_rsp.done) state <= S_D3W;
        S_D3W: if (div_rsp.done) state <= S_RY;
        S_RY:  state <= S_RYL;
        S_RYL: state <= S_RYW;
        S_RYW: if (div_rsp.done) state <= S_CX;
        S_CX:  state <= S_CXL;
        S_CXL: state <= S_CXW;
        S_CXW: if (div_rsp.done) state <= S_W;
        S_W:   state <= S_WP;
        S_WP:  state <= S_PM;
        S_PM:  state <= S_PA;
        S_PA: begin
          if (p != LAST_PLANE) state <= S_PM;
          else if (sx != sx1) state <= S_CX;
          else if (sy != sy1) state <= S_RY;
          else state <= S_FM;
        end
        S_FM: begin
          if (plane_used) state <= S_FH;
          else if (p == LAST_PLANE) state <= S_OUT;
        end
        S_FH:  state <= S_FS;
        S_FS:  state <= S_FW;
        S_FW: begin
          if (div_rsp.done) state <= (p == LAST_PLANE) ? S_OUT : S_FM;
        end
        S_OUT: if (!out_valid || out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // request datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        col <= in_ch.pix_col;
        row <= in_ch.pix_row;
      end
      S_MY:  xlo  <= mul_p[16:0];
      S_MA:  ylo  <= mul_p[16:0];
      S_MD:  area <= mul_p[16:0];
      S_D0:  dd   <= mul_p[16:0];
      S_D0W: if (div_rsp.done) sx0 <= div_rsp.quot[7:0];
      S_D1W: if (div_rsp.done) sx1 <= clamp_last(div_rsp.quot[16:0], sw);
      S_D2W: if (div_rsp.done) sy  <= div_rsp.quot[7:0];
      S_D3W: begin
        if (div_rsp.done) begin
          sy1 <= clamp_last(div_rsp.quot[16:0], sh);
          for (int i = 0; i < aais_pkg::PLANES; i++) acc[i] <= '0;
        end
      end
      S_RYW: begin
        if (div_rsp.done) begin
          wy <= div_rsp.quot[16:0];
          sx <= sx0;
        end
      end
      S_CXW: if (div_rsp.done) wx <= div_rsp.quot[16:0];
      S_WP: begin
        w   <= mul_p[32:0];
        pix <= st_rdata;
        p   <= 3'd0;
      end
      S_PA: begin
        acc[p] <= acc[p] + {17'd0, mul_p[40:0]};
        if (p != LAST_PLANE) begin
          p <= p + 3'd1;
        end else begin
          p <= 3'd0;
          if (sx != sx1) sx <= sx + 8'd1;
          else if (sy != sy1) sy <= sy + 8'd1;
        end
      end
      S_FM: begin
        if (!plane_used) begin
          res[p] <= '0;
          if (p != LAST_PLANE) p <= p + 3'd1;
        end
      end
      S_FH: lo_prod <= mul_p[45:0];
      S_FW: begin
        if (div_rsp.done) begin
          // quotient >> 32, clamped to a byte
          res[p] <= (div_rsp.quot[63:40] != 24'd0) ? 8'hFF : div_rsp.quot[39:32];
          if (p != LAST_PLANE) p <= p + 3'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_a     <= res[0];
      o_b     <= res[1];
      o_c     <= res[2];
      o_d     <= res[3];
      o_alpha <= res[4];
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.out_a     = o_a;
  assign out_ch.out_b     = o_b;
  assign out_ch.out_c     = o_c;
  assign out_ch.out_d     = o_d;
  assign out_ch.out_alpha = o_alpha;

  // in-range request starts the walk
  `AAIS_ASSERT_NEXT(a_req_start, req_go, state == S_MX, "request did not start")
  // the walk never leaves the footprint
  `AAIS_ASSERT_NOW(a_walk_bounds, state == S_W, sx <= sx1 && sy <= sy1 && sx0 <= sx1, "walk out of footprint")
  // divider only finishes while the sequencer waits on it
  `AAIS_ASSERT_NOW(a_div_wait, div_rsp.done, div_waiting, "stray divider result")
  // finished item lands in the output register
  `AAIS_ASSERT_NEXT(a_out_load, out_load, out_valid && state == S_IDLE, "result not posted")

endmodule

`default_nettype wire

### verif/area_average_image_scaler_checker.sv
// scoreboard for the area-average image scaler: predicts averaged pixels and compares
`timescale 1ns / 100ps

module area_average_image_scaler_checker
  import aais_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  aais_in_if         in_ch,
  aais_out_if        out_ch,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [8:0] cfg_data,
  output int         fail_count,
  output int         awaited,
  output int         pixels_checked
);

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] d;
    logic [7:0] alpha;
  } avg_pixel_t;

  logic [7:0] frame [MAX_WIDTH*MAX_HEIGHT][PLANES];
  int unsigned src_w, src_h, dst_w, dst_h, chans;
  avg_pixel_t pending_pixels[$];

  initial begin
    fail_count = 0;
    awaited = 0;
    pixels_checked = 0;
  end

  function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // q1.16 share of cell s (size d) inside the span [lo, hi)
  function automatic longint unsigned cover_weight(longint unsigned lo, longint unsigned hi,
                                                   longint unsigned s, longint unsigned d);
    longint unsigned cs, ce, a, b, len;
    cs = s * d;
    ce = cs + d;
    a = (lo > cs) ? lo : cs;
    b = (hi < ce) ? hi : ce;
    len = (b > a) ? b - a : 0;
    return (len * 65536 + d / 2) / d;
  endfunction

  function automatic avg_pixel_t average_footprint(int unsigned col, int unsigned row);
    longint unsigned xlo, xhi, ylo, yhi, sx0, sx1, sy0, sy1, wy, w, area, v;
    longint unsigned sums [PLANES];
    logic [7:0] planes_out [PLANES];
    xlo = col * src_w;
    xhi = xlo + src_w;
    ylo = row * src_h;
    yhi = ylo + src_h;
    sx0 = xlo / dst_w;
    sx1 = (xhi - 1) / dst_w;
    sy0 = ylo / dst_h;
    sy1 = (yhi - 1) / dst_h;
    area = longint'(src_w) * src_h;
    if (sx1 >= src_w) sx1 = src_w - 1;
    if (sy1 >= src_h) sy1 = src_h - 1;
    for (int p = 0; p < PLANES; p++) sums[p] = 0;
    for (longint unsigned sy = sy0; sy <= sy1; sy++) begin
      wy = cover_weight(ylo, yhi, sy, dst_h);
      for (longint unsigned sx = sx0; sx <= sx1; sx++) begin
        w = cover_weight(xlo, xhi, sx, dst_w) * wy;
        for (int p = 0; p < PLANES; p++)
          sums[p] += longint'(frame[sy*MAX_WIDTH + sx][p]) * w;
      end
    end
    for (int p = 0; p < PLANES; p++) begin
      v = 0;
      if (p == PLANES - 1 || p < chans) begin
        v = ((sums[p] * dst_w * dst_h) / area) >> 32;
        if (v > 255) v = 255;
      end
      planes_out[p] = v[7:0];
    end
    return '{planes_out[0], planes_out[1], planes_out[2], planes_out[3], planes_out[4]};
  endfunction

  function automatic void check_plane(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    avg_pixel_t want;
    if (rst) begin
      src_w = MAX_WIDTH;
      src_h = MAX_HEIGHT;
      dst_w = MAX_WIDTH;
      dst_h = MAX_HEIGHT;
      chans = 3;
      pending_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SRC_WIDTH:  src_w = clamp_to(cfg_data, 1, MAX_WIDTH);
          REG_SRC_HEIGHT: src_h = clamp_to(cfg_data, 1, MAX_HEIGHT);
          REG_DST_WIDTH:  dst_w = clamp_to(cfg_data, 1, MAX_WIDTH);
          REG_DST_HEIGHT: dst_h = clamp_to(cfg_data, 1, MAX_HEIGHT);
          REG_CHAN_COUNT: chans = clamp_to(cfg_data[2:0], 1, MAX_CHANNELS);
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.kind == KIND_LOAD) begin
          frame[in_ch.pix_row*MAX_WIDTH + in_ch.pix_col] =
            '{in_ch.chan_a, in_ch.chan_b, in_ch.chan_c, in_ch.chan_d, in_ch.alpha_in};
        end else if (in_ch.pix_col < dst_w && in_ch.pix_row < dst_h) begin
          pending_pixels.push_back(average_footprint(in_ch.pix_col, in_ch.pix_row));
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_pixels.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual %h", $time,
                   {out_ch.out_a, out_ch.out_b, out_ch.out_c, out_ch.out_d, out_ch.out_alpha});
          fail_count++;
        end else begin
          want = pending_pixels.pop_front();
          check_plane("out_a", want.a, out_ch.out_a);
          check_plane("out_b", want.b, out_ch.out_b);
          check_plane("out_c", want.c, out_ch.out_c);
          check_plane("out_d", want.d, out_ch.out_d);
          check_plane("out_alpha", want.alpha, out_ch.out_alpha);
          pixels_checked++;
        end
      end
    end
    awaited = pending_pixels.size();
  end

endmodule

### verif/area_average_image_scaler_top_test.sv
// top of the area-average image scaler testbench: stimulus, configuration and verdict
`timescale 1ns / 100ps

module area_average_image_scaler_top_test;
  import aais_pkg::*;

  localparam logic [2:0] UNUSED_REG_INDEX = 3'd7;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [8:0] cfg_data;

  int fail_count, awaited, pixels_checked;
  int items_sent = 0;
  int requests_sent = 0;
  int phases_run = 0;
  bit idle_on = 1;
  int ready_hold = 0;

  // effective sizes, used to load the whole source and keep requests inside the destination
  int unsigned eff_sw, eff_sh, eff_dw, eff_dh;

  aais_in_if  in_ch ();
  aais_out_if out_ch ();

  area_average_image_scaler_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  area_average_image_scaler_checker scoreboard (
    .clk            (clk),
    .rst            (rst),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .awaited        (awaited),
    .pixels_checked (pixels_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous ceiling, far above the slowest legal run
  initial begin
    #1_000_000_000;
    $display("area_average_image_scaler_top_test: done, errors");
    $finish;
  end

  // result side back-pressure: short random stall bursts while idling is on
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      out_ch.ready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      ready_hold <= $urandom_range(0, 2);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  function automatic int unsigned clamp_size(int unsigned raw);
    if (raw < 1) return 1;
    if (raw > 256) return 256;
    return raw;
  endfunction

  // one item on the input channel; valid stays high into the next item
  task automatic send_item(input logic kind, input logic [7:0] col, input logic [7:0] row,
                           input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
                           input logic [7:0] d, input logic [7:0] al);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.kind     <= kind;
    in_ch.pix_col  <= col;
    in_ch.pix_row  <= row;
    in_ch.chan_a   <= a;
    in_ch.chan_b   <= b;
    in_ch.chan_c   <= c;
    in_ch.chan_d   <= d;
    in_ch.alpha_in <= al;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    if (kind == KIND_REQUEST) requests_sent++;
  endtask

  task automatic load_pixel(input logic [7:0] col, input logic [7:0] row);
    send_item(KIND_LOAD, col, row, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom));
  endtask

  // request items carry junk in the channel fields, the block must ignore it
  task automatic request_pixel(input logic [7:0] col, input logic [7:0] row);
    send_item(KIND_REQUEST, col, row, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom));
  endtask

  // fill the whole active source area so no request reads an unwritten entry
  task automatic load_source();
    for (int r = 0; r < eff_sh; r++)
      for (int c = 0; c < eff_sw; c++)
        load_pixel(8'(c), 8'(r));
  endtask

  // stop the input, let every awaited item arrive, then give the block time
  // to finish a request that yields nothing
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [8:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // block is idle here; raw values may lie outside the legal range
  task automatic configure(input logic [8:0] sw, input logic [8:0] sh, input logic [8:0] dw,
                           input logic [8:0] dh, input logic [8:0] chans);
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_DST_WIDTH, dw);
    write_reg(REG_DST_HEIGHT, dh);
    write_reg(REG_CHAN_COUNT, chans);
    cfg_we <= 1'b0;
    @(posedge clk);
    eff_sw = clamp_size(sw);
    eff_sh = clamp_size(sh);
    eff_dw = clamp_size(dw);
    eff_dh = clamp_size(dh);
    phases_run++;
  endtask

  function automatic logic [8:0] pick_size();
    case ($urandom_range(0, 19))
      0: return 9'd0;                          // saturates up to one
      1: return 9'($urandom_range(257, 511));  // saturates down to the max
      default: return 9'($urandom_range(1, 5));
    endcase
  endfunction

  initial begin
    logic [8:0] sw, sh, dw, dh;
    int ops;

    in_ch.valid    <= 1'b0;
    in_ch.kind     <= KIND_LOAD;
    in_ch.pix_col  <= '0;
    in_ch.pix_row  <= '0;
    in_ch.chan_a   <= '0;
    in_ch.chan_b   <= '0;
    in_ch.chan_c   <= '0;
    in_ch.chan_d   <= '0;
    in_ch.alpha_in <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_SRC_WIDTH;
    cfg_data       <= '0;
    eff_sw = 256;
    eff_sh = 256;
    eff_dw = 256;
    eff_dh = 256;
    rst <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset sizes: one-to-one footprint, three channels in use, corner values
    send_item(KIND_LOAD, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(KIND_LOAD, 8'd255, 8'd255, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    send_item(KIND_LOAD, 8'd170, 8'd85, 8'h55, 8'haa, 8'h55, 8'haa, 8'h55);
    send_item(KIND_LOAD, 8'd85, 8'd170, 8'haa, 8'h55, 8'haa, 8'h55, 8'haa);
    request_pixel(8'd0, 8'd0);
    request_pixel(8'd255, 8'd255);
    request_pixel(8'd170, 8'd85);
    request_pixel(8'd85, 8'd170);
    drain();

    // widest source folded into one pixel: every weight is a whole pixel
    configure(9'd256, 9'd1, 9'd1, 9'd1, 9'd4);
    load_source();
    request_pixel(8'd0, 8'd0);
    request_pixel(8'd1, 8'd0);  // outside destination, nothing comes back
    request_pixel(8'd0, 8'd1);
    request_pixel(8'd0, 8'd0);
    drain();

    // one source column spread over 256 destination columns, tallest source
    configure(9'd1, 9'd256, 9'd256, 9'd1, 9'd1);
    load_source();
    request_pixel(8'd0, 8'd0);
    request_pixel(8'd255, 8'd0);
    request_pixel(8'd7, 8'd0);
    request_pixel(8'd7, 8'd1);
    drain();

    // out-of-range register values saturate; an unused index is ignored
    configure(9'd0, 9'd0, 9'd511, 9'd300, 9'd0);
    write_reg(UNUSED_REG_INDEX, 9'h1ff);
    cfg_we <= 1'b0;
    @(posedge clk);
    load_source();
    for (int i = 0; i < 6; i++) request_pixel(8'($urandom), 8'($urandom));
    drain();

    // random phases: small sizes so requests stay cheap, full source loaded
    // first, then mostly well-formed requests mixed with reloads and noise
    while (items_sent < 1800 || pixels_checked < 60) begin
      if (items_sent > 1550) idle_on = 0;
      sw = pick_size();
      sh = pick_size();
      dw = pick_size();
      dh = pick_size();
      if (clamp_size(sw) * clamp_size(sh) > 64 || clamp_size(dw) > 64 || clamp_size(dh) > 64)
        continue;
      configure(sw, sh, dw, dh, 9'($urandom_range(0, 7)));
      load_source();
      ops = $urandom_range(8, 20);
      for (int i = 0; i < ops; i++) begin
        case ($urandom_range(0, 19))
          0, 1, 2: load_pixel(8'($urandom_range(0, eff_sw - 1)),
                              8'($urandom_range(0, eff_sh - 1)));
          3, 4:    load_pixel(8'($urandom), 8'($urandom));  // lands anywhere in the store
          5, 6:    request_pixel(8'($urandom), 8'($urandom));  // mostly outside destination
          default: request_pixel(8'($urandom_range(0, eff_dw - 1)),
                                 8'($urandom_range(0, eff_dh - 1)));
        endcase
      end
      drain();
    end

    $display("covered %0d items (%0d requests) over %0d register settings",
             items_sent, requests_sent, phases_run);
    $display("checked %0d averaged pixels", pixels_checked);
    if (fail_count == 0 && awaited == 0) begin
      $display("area_average_image_scaler_top_test: done, clean");
    end else begin
      $display("area_average_image_scaler_top_test: done, errors");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/aais_pkg.sv
design/aais_in_if.sv
design/aais_out_if.sv
design/aais_div.sv
design/aais_store.sv
design/area_average_image_scaler_top.sv
verif/area_average_image_scaler_checker.sv
verif/area_average_image_scaler_top_test.sv
